/* design/rasr_pkg.sv */
// Shared constants and types for the row absolute-sum reciprocal block.
package rasr_pkg;
  localparam int unsigned MaxRows = 8;
  localparam int unsigned RowW = 3;
  localparam int unsigned SumW = 48;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW = 2;
  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};
  localparam logic [31:0] OneQ16 = 32'h0001_0000;

  typedef struct packed {
    logic [SumW-1:0] sum;
    logic [RowW-1:0] row;
    logic            last;
  } job_t;
endpackage

/* design/rasr_front.sv */
// Front end: accumulates per-row magnitude sums and emits one job per row at block end.
module rasr_front import rasr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] value_i,
  input  logic [2:0]  sub_row_i,
  input  logic        has_value_i,
  input  logic        end_of_row_i,
  input  logic [3:0]  rows_i,
  output logic        job_valid_o,
  input  logic        job_ready_i,
  output job_t        job_o
);
  logic [SumW-1:0] sums_q [MaxRows];
  logic [SumW-1:0] snap_q [MaxRows];
  logic            drain_q;
  logic [RowW-1:0] idx_q;
  logic [RowW-1:0] last_q;
  logic [3:0]      n;
  logic [31:0]     mag;
  logic [SumW:0]   add;
  logic [SumW-1:0] addsat;
  logic            acc;

  always_comb begin
    n = rows_i;
    if (n == 4'd0) n = 4'd1;
    if (n > 4'(MaxRows)) n = 4'(MaxRows);
    mag = value_i[31] ? (32'd0 - value_i) : value_i;
    add = {1'b0, sums_q[sub_row_i]} + {{(SumW-31){1'b0}}, mag};
    addsat = add[SumW] ? SumMax : add[SumW-1:0];
  end

  assign in_ready_o = !drain_q;
  assign acc = in_valid_i && in_ready_o;
  assign job_valid_o = drain_q;
  assign job_o = '{sum: snap_q[idx_q], row: idx_q, last: idx_q == last_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxRows; i++) sums_q[i] <= '0;
      drain_q <= 1'b0;
      idx_q <= '0;
      last_q <= '0;
    end else begin
      if (acc) begin
        if (end_of_row_i) begin
          for (int i = 0; i < MaxRows; i++) sums_q[i] <= '0;
          drain_q <= 1'b1;
          idx_q <= '0;
          last_q <= RowW'(n - 4'd1);
        end else if (has_value_i && ({1'b0, sub_row_i} < n)) begin
          sums_q[sub_row_i] <= addsat;
        end
      end
      if (drain_q && job_ready_i) begin
        if (idx_q == last_q) drain_q <= 1'b0;
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && end_of_row_i) begin
      for (int i = 0; i < MaxRows; i++) begin
        if (has_value_i && ({1'b0, sub_row_i} < n) && (sub_row_i == RowW'(i))) begin
          snap_q[i] <= addsat;
        end else begin
          snap_q[i] <= sums_q[i];
        end
      end
    end
  end
endmodule

/* design/rasr_queue.sv */
// Small job queue between the front and back ends.
module rasr_queue import rasr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  output logic full_o,
  input  job_t data_i,
  input  logic pop_i,
  output logic empty_o,
  output job_t data_o
);
  job_t           mem_q [QDepth];
  logic [QPtrW-1:0] wp_q, rp_q;
  logic [QPtrW:0]   cnt_q;
  logic wr, rd;

  assign full_o = cnt_q == (QPtrW+1)'(QDepth);
  assign empty_o = cnt_q == '0;
  assign wr = push_i && !full_o;
  assign rd = pop_i && !empty_o;
  assign data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 1'b1;
      if (rd) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (QPtrW+1)'(wr) - (QPtrW+1)'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= data_i;
  end
endmodule

/* design/rasr_back.sv */
// Back end: radix-2 restoring divider, capped round(2^32/sum) for sum>0.
module rasr_back import rasr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_empty_i,
  output logic        job_pop_o,
  input  job_t        job_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [31:0] scale_o,
  output logic        row_was_zero_o,
  output logic [2:0]  row_in_block_o,
  output logic        last_o
);
  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StDiv  = 3'b010,
    StOut  = 3'b100
  } state_e;

  localparam int unsigned NumW = 50;
  localparam int unsigned StepW = 6;

  state_e           state_q;
  logic [NumW-1:0]  num_q;
  logic [SumW:0]    rem_q;
  logic [SumW-1:0]  div_q;
  logic [StepW-1:0] step_q;
  logic [RowW-1:0]  row_q;
  logic             last_q, zero_q;
  logic [31:0]      scale_q;
  logic [SumW:0]    trial;
  logic [SumW+1:0]  diff;

  assign trial = {rem_q[SumW-1:0], num_q[NumW-1]};
  assign diff = {1'b0, trial} - {2'b0, div_q};
  assign job_pop_o = (state_q == StIdle) && !job_empty_i;
  assign empty_o = state_q != StOut;
  assign scale_o = scale_q;
  assign row_was_zero_o = zero_q;
  assign row_in_block_o = row_q;
  assign last_o = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q <= '0;
    end else begin
      case (state_q)
        StIdle: if (!job_empty_i) begin
          state_q <= (job_i.sum == '0) ? StOut : StDiv;
          step_q <= '0;
        end
        StDiv: begin
          step_q <= step_q + 1'b1;
          if (step_q == StepW'(NumW - 1)) state_q <= StOut;
        end
        StOut: if (pop_i) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        row_q <= job_i.row;
        last_q <= job_i.last;
        zero_q <= job_i.sum == '0;
        div_q <= job_i.sum;
        num_q <= (NumW'(1) << 32) + NumW'(job_i.sum >> 1);
        rem_q <= '0;
        scale_q <= OneQ16;
      end
      StDiv: begin
        if (!diff[SumW+1]) begin
          rem_q <= diff[SumW:0];
          num_q <= {num_q[NumW-2:0], 1'b1};
        end else begin
          rem_q <= trial;
          num_q <= {num_q[NumW-2:0], 1'b0};
        end
        if (step_q == StepW'(NumW - 1)) begin
          if (|num_q[NumW-2:31]) scale_q <= '1;
          else scale_q <= {num_q[30:0], !diff[SumW+1]};
        end
      end
      default: ;
    endcase
  end
endmodule

/* design/row_abs_sum_reciprocal.sv */
// Top level of the row absolute-sum reciprocal block.
//  channel | handshake        | beat
//  input   | push / full      | value_i, sub_row_i, has_value_i, end_of_row_i
//  result  | pop / empty      | scale_o, row_was_zero_o, row_in_block_o, last_o
//  config  | cfg_valid_i/ready| cfg_data_i (rows_per_block)
// One input beat per cycle while no block end is being unloaded; an end beat stalls
// input until each row's job has entered the 4-deep job queue, longer while that queue is full.
// Each nonzero row goes through the serial divider; a zero row skips it.
// Reset clears sums and sets rows_per_block to 1. Either side may stall freely.
module row_abs_sum_reciprocal import rasr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [31:0] value_i,
  input  logic [2:0]  sub_row_i,
  input  logic        has_value_i,
  input  logic        end_of_row_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] scale_o,
  output logic        row_was_zero_o,
  output logic [2:0]  row_in_block_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_data_i
);
  logic [3:0] rows_q;
  logic in_ready, job_valid, q_full, q_empty, q_pop;
  job_t job, q_job;

  assign cfg_ready_o = 1'b1;
  assign full = !in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rows_q <= 4'd1;
    else if (cfg_valid_i && cfg_ready_o) rows_q <= cfg_data_i;
  end

  rasr_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(push), .in_ready_o(in_ready),
    .value_i, .sub_row_i, .has_value_i, .end_of_row_i,
    .rows_i(rows_q),
    .job_valid_o(job_valid), .job_ready_i(!q_full), .job_o(job)
  );

  rasr_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(job_valid), .full_o(q_full), .data_i(job),
    .pop_i(q_pop), .empty_o(q_empty), .data_o(q_job)
  );

  rasr_back u_back (
    .clk_i, .rst_ni,
    .job_empty_i(q_empty), .job_pop_o(q_pop), .job_i(q_job),
    .empty_o(empty), .pop_i(pop),
    .scale_o, .row_was_zero_o, .row_in_block_o, .last_o
  );
endmodule

/* design/rasr_checker.sv */
// Port-level checker for the row absolute-sum reciprocal block, with its bind.
module rasr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [31:0] scale_o,
  input logic        row_was_zero_o,
  input logic [2:0]  row_in_block_o,
  input logic        last_o
);
  a_zero_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && row_was_zero_o |-> scale_o == 32'h0001_0000) else $error("zero row scale");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(scale_o)) else $error("result dropped");
  a_next_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && pop && !last_o ##1 !empty |-> row_in_block_o == $past(row_in_block_o) + 3'd1)
    else $error("row order");
  a_first_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && pop && last_o ##1 !empty |-> row_in_block_o == 3'd0) else $error("row restart");
endmodule

bind row_abs_sum_reciprocal rasr_checker u_rasr_checker (.*);
